### rtl/core/stcm_pkg.sv
`default_nettype none

package stcm_pkg;

    // Sizing of the block
    localparam int MAX_COLORS      = 256;
    localparam int LOG_TABLE_DEPTH = 1024;
    localparam int MAX_REPEAT      = 16;

    localparam int CIDX_W    = $clog2(MAX_COLORS);
    localparam int CNT_W     = $clog2(MAX_COLORS + 1);
    localparam int LOG_IDX_W = $clog2(LOG_TABLE_DEPTH);
    localparam int REP_W     = $clog2(MAX_REPEAT + 1);

    // Color index before the wrap, and the wrap pipeline split
    localparam int IDX_W       = 16;
    localparam int WRAP_BITS   = 2;
    localparam int WRAP_STAGES = IDX_W / WRAP_BITS;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Log table: Q1.16 entries
    localparam int LOG_Q_W = 17;
    localparam logic [63:0] E10M1_Q16     = 64'd1443460926;
    localparam logic [63:0] LN2_DIV10_Q32 = 64'd297704447;

    // Mode bits
    localparam int MODE_LOG     = 0;
    localparam int MODE_REVERSE = 1;
    localparam int MODE_CMAP    = 2;

    // Input kinds
    localparam logic ACT_MAP   = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef enum logic [2:0] {
        REG_LOW_CUT      = 3'd0,
        REG_HIGH_CUT     = 3'd1,
        REG_INDEX_GAIN   = 3'd2,
        REG_LOG_SPAN     = 3'd3,
        REG_DISPLAY_MODE = 3'd4,
        REG_COLOR_COUNT  = 3'd5,
        REG_REPEAT_COUNT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] low_cut;
        logic signed [31:0] high_cut;
        logic [31:0]        index_gain;
        logic [15:0]        log_span;
        logic [2:0]         display_mode;
        logic [8:0]         color_count;
        logic [4:0]         repeat_count;
    } t_cfg;

    // One queued item: offset for a sample, {index, red, green, blue} for a write
    typedef struct packed {
        logic        wr;
        logic [31:0] data;
    } t_item;

    typedef logic [LOG_Q_W-1:0] t_log_rom [LOG_TABLE_DEPTH];

    // log2 of a Q16 value x >= 1.0, Q16 result, truncated
    function automatic logic [63:0] log2_q16(input logic [63:0] x);
        int          n;
        logic [63:0] y;
        logic [63:0] r;
        n = 16;
        for (int j = 0; j < 14; j++) begin
            if (n < 30 && (x >> (n + 1)) != 64'd0) begin
                n = n + 1;
            end
        end
        y = x << (30 - n);
        r = 64'(n - 16) << 16;
        for (int i = 15; i >= 0; i--) begin
            y = (y * y) >> 30;
            if (y >= (64'd2 << 30)) begin
                y = y >> 1;
                r = r | (64'd1 << i);
            end
        end
        return r;
    endfunction

    function automatic logic [LOG_Q_W-1:0] log_entry(input int k);
        logic [63:0] x;
        logic [63:0] v;
        if (k >= LOG_TABLE_DEPTH - 1) begin
            return LOG_Q_W'(65536);
        end
        x = 64'd65536 + (64'(k) * E10M1_Q16) / 64'(LOG_TABLE_DEPTH - 1);
        v = (log2_q16(x) * LN2_DIV10_Q32 + (64'd1 << 31)) >> 32;
        return (v > 64'd65536) ? LOG_Q_W'(65536) : v[LOG_Q_W-1:0];
    endfunction

    function automatic t_log_rom build_log_rom();
        t_log_rom rom;
        for (int k = 0; k < LOG_TABLE_DEPTH; k++) begin
            rom[k] = log_entry(k);
        end
        return rom;
    endfunction

    localparam t_log_rom LOG_ROM = build_log_rom();

endpackage

`default_nettype wire

### rtl/core/stcm_ram.sv
`default_nettype none

module stcm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/stcm_queue.sv
`default_nettype none

module stcm_queue
    import stcm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == (QPTR_W + 1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/stcm_front.sv
`default_nettype none

module stcm_front
    import stcm_pkg::*;
(
    input  wire logic        i_valid,
    input  wire logic [63:0] i_data,
    input  wire logic        i_kind,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_full,
    output logic             o_ready,
    output logic             o_push,
    output t_item            o_item
);

    logic signed [31:0] sample;
    logic signed [32:0] diff_s;
    logic signed [32:0] diff_h;
    logic               s_gt_hi;
    logic               s_gt_lo;
    logic               hi_gt_lo;
    logic [31:0]        offset;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // Clip and subtract in parallel, then pick
    always_comb begin
        sample   = signed'(i_data[31:0]);
        diff_s   = {sample[31], sample} - {i_cfg.low_cut[31], i_cfg.low_cut};
        diff_h   = {i_cfg.high_cut[31], i_cfg.high_cut} - {i_cfg.low_cut[31], i_cfg.low_cut};
        s_gt_hi  = sample > i_cfg.high_cut;
        s_gt_lo  = sample > i_cfg.low_cut;
        hi_gt_lo = i_cfg.high_cut > i_cfg.low_cut;
        if (s_gt_hi) begin
            offset = hi_gt_lo ? diff_h[31:0] : '0;
        end else begin
            offset = s_gt_lo ? diff_s[31:0] : '0;
        end
        o_item.wr   = (i_kind == ACT_WRITE);
        // writes are packed index first, then red, green, blue
        o_item.data = (i_kind == ACT_WRITE) ?
                      {i_data[39:32], i_data[47:40], i_data[55:48], i_data[63:56]} : offset;
    end

endmodule

`default_nettype wire

### rtl/core/stcm_wrap.sv
`default_nettype none

module stcm_wrap
    import stcm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_adv,
    input  wire logic             i_valid,
    input  wire t_item            i_side,
    input  wire logic [IDX_W-1:0] i_idx,
    input  wire logic [CNT_W-1:0] i_cnt,
    output logic                  o_valid,
    output t_item                 o_side,
    output logic      [CNT_W-1:0] o_rem
);

    logic             r_vld  [WRAP_STAGES];
    t_item            r_side [WRAP_STAGES];
    logic [CNT_W-1:0] r_rem  [WRAP_STAGES];
    logic [IDX_W-1:0] r_bits [WRAP_STAGES];
    logic [CNT_W-1:0] n_rem  [WRAP_STAGES];
    logic [IDX_W-1:0] n_bits [WRAP_STAGES];

    // Restoring remainder, WRAP_BITS quotient bits per stage
    for (genvar s = 0; s < WRAP_STAGES; s++) begin : g_stage
        logic [CNT_W-1:0] rem_in;
        logic [IDX_W-1:0] bits_in;
        logic             vld_in;
        t_item            side_in;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign bits_in = i_idx;
            assign vld_in  = i_valid;
            assign side_in = i_side;
        end else begin : g_next
            assign rem_in  = r_rem[s-1];
            assign bits_in = r_bits[s-1];
            assign vld_in  = r_vld[s-1];
            assign side_in = r_side[s-1];
        end

        always_comb begin
            logic [CNT_W:0]   trial;
            logic [CNT_W-1:0] rem;
            logic [IDX_W-1:0] bits;
            rem  = rem_in;
            bits = bits_in;
            for (int b = 0; b < WRAP_BITS; b++) begin
                trial = {rem, bits[IDX_W-1]};
                if (trial >= {1'b0, i_cnt}) begin
                    trial = trial - {1'b0, i_cnt};
                end
                rem  = trial[CNT_W-1:0];
                bits = bits << 1;
            end
            n_rem[s]  = rem;
            n_bits[s] = bits;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_adv) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[s] <= side_in;
                r_rem[s]  <= n_rem[s];
                r_bits[s] <= n_bits[s];
            end
        end
    end

    assign o_valid = r_vld[WRAP_STAGES-1];
    assign o_side  = r_side[WRAP_STAGES-1];
    assign o_rem   = r_rem[WRAP_STAGES-1];

endmodule

`default_nettype wire

### rtl/core/stcm_back.sv
`default_nettype none

module stcm_back
    import stcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_valid,
    input  wire t_item       i_q_item,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_pixel,
    output logic             o_last
);

    logic              adv;
    logic              slot_free;
    logic [CNT_W-1:0]  cnt;
    logic [REP_W-1:0]  reps;

    logic              r_s1_valid;
    t_item             r_s1;
    logic [47:0]       r_s1_prod;
    logic [63:0]       mult1;

    logic              r_s2_valid;
    t_item             r_s2;
    logic [IDX_W-1:0]  r_s2_lin;
    logic [LOG_Q_W-1:0] r_s2_rom;
    logic [LOG_IDX_W-1:0] rom_addr;

    logic              r_s3_valid;
    t_item             r_s3;
    logic [IDX_W-1:0]  r_s3_idx;
    logic [LOG_Q_W+15:0] mult3;

    logic              wrap_valid;
    t_item             wrap_side;
    logic [CNT_W-1:0]  wrap_rem;

    logic              r_s4_valid;
    t_item             r_s4;
    logic [CIDX_W-1:0] r_s4_c;

    logic              ram_we;
    logic [CIDX_W-1:0] ram_addr;
    logic [23:0]       ram_rdata;

    logic              r_s5_valid;
    logic [7:0]        r_s5_gray;

    logic              r_out_valid;
    logic [23:0]       r_out_pixel;
    logic              r_out_last;
    logic [REP_W-1:0]  r_left;

    // Clamp the wrap modulus and copy count
    always_comb begin
        if (i_cfg.color_count == '0) begin
            cnt = CNT_W'(1);
        end else if (32'(i_cfg.color_count) > MAX_COLORS) begin
            cnt = CNT_W'(MAX_COLORS);
        end else begin
            cnt = CNT_W'(i_cfg.color_count);
        end
        if (i_cfg.repeat_count == '0) begin
            reps = REP_W'(1);
        end else if (32'(i_cfg.repeat_count) > MAX_REPEAT) begin
            reps = REP_W'(MAX_REPEAT);
        end else begin
            reps = REP_W'(i_cfg.repeat_count);
        end
    end

    // Whole pipeline moves together; it halts only when the copy register is busy
    assign slot_free = !r_out_valid || (i_ready && r_out_last);
    assign adv       = !r_s5_valid || slot_free;
    assign o_pop     = adv && i_q_valid;

    assign mult1    = {32'b0, i_q_item.data} * {32'b0, i_cfg.index_gain};
    assign rom_addr = (r_s1_prod > 48'(LOG_TABLE_DEPTH - 1)) ?
                      LOG_IDX_W'(LOG_TABLE_DEPTH - 1) : r_s1_prod[LOG_IDX_W-1:0];
    assign mult3    = {15'b0, r_s2_rom} * {{(LOG_Q_W-1){1'b0}}, i_cfg.log_span};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= i_q_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= wrap_valid;
            r_s5_valid <= r_s4_valid && !r_s4.wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1      <= i_q_item;
            r_s1_prod <= mult1[63:16];

            r_s2      <= r_s1;
            r_s2_lin  <= (r_s1_prod[47:16] != '0) ? '1 : r_s1_prod[15:0];
            r_s2_rom  <= LOG_ROM[rom_addr];

            r_s3      <= r_s2;
            r_s3_idx  <= i_cfg.display_mode[MODE_LOG] ? mult3[31:16] : r_s2_lin;

            r_s4      <= wrap_side;
            r_s4_c    <= i_cfg.display_mode[MODE_REVERSE] ?
                         CIDX_W'(cnt - CNT_W'(1) - wrap_rem) : CIDX_W'(wrap_rem);

            r_s5_gray <= 8'(r_s4_c);
        end
    end

    stcm_wrap u_wrap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s3_valid),
        .i_side  (r_s3),
        .i_idx   (r_s3_idx),
        .i_cnt   (cnt),
        .o_valid (wrap_valid),
        .o_side  (wrap_side),
        .o_rem   (wrap_rem)
    );

    // Colormap writes and reads share one port, in stream order
    assign ram_we   = r_s4_valid && r_s4.wr && (32'(r_s4.data[31:24]) < MAX_COLORS);
    assign ram_addr = r_s4.wr ? CIDX_W'(r_s4.data[31:24]) : r_s4_c;

    stcm_ram #(
        .WIDTH (24),
        .DEPTH (MAX_COLORS)
    ) u_cmap (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (r_s4.data[23:0]),
        .o_rdata (ram_rdata)
    );

    // Copy register: hold the pixel for reps transfers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s5_valid) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && i_ready && r_out_last) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s5_valid) begin
            // table holds red in the top byte; the stream carries red lowest
            r_out_pixel <= i_cfg.display_mode[MODE_CMAP] ?
                           {ram_rdata[7:0], ram_rdata[15:8], ram_rdata[23:16]} :
                           {r_s5_gray, r_s5_gray, r_s5_gray};
            r_left      <= reps - 1'b1;
            r_out_last  <= (reps == REP_W'(1));
        end else if (r_out_valid && i_ready && !r_out_last) begin
            r_left      <= r_left - 1'b1;
            r_out_last  <= (r_left == REP_W'(1));
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_out_pixel;
    assign o_last  = r_out_last;

endmodule

`default_nettype wire

### rtl/core/sample_to_color_mapper.sv
// Sample to color mapper: turns a stream of signed image samples into display colors.
//
// Input stream (s side): one transfer per item. tuser selects the kind: 0 maps the
// sample in tdata[31:0], 1 writes colormap entry tdata[39:32] with red, green, blue
// in tdata[47:40], [55:48], [63:56]. A colormap write produces no output.
// Output stream (m side): tdata carries red, green, blue from the lowest byte up;
// each pixel goes out repeat_count times, clamped to 1..16; tlast marks the last copy.
// Configuration: APB registers low_cut, high_cut, index_gain, log_span,
// display_mode, color_count, repeat_count at byte addresses 0, 4, ..., 24.
// Program them only while the stream is idle.
// Each item passes the queue, the gain, log, index, wrap, reverse and colormap
// stages and the copy register. Throughput: one item per cycle when repeat_count is
// 1 and m_tready is high; else the copy register sends each pixel repeat_count times.
// A 4-deep queue decouples the input side, so tready stays high until it fills.
// When the receiver stalls, the mapping pipeline holds in place and the queue
// absorbs up to four more items. Reset clears the queue, pipeline and output;
// registers return to their defaults; colormap contents are undefined until written.
`default_nettype none

module sample_to_color_mapper
    import stcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [63:0] i_s_tdata,  // sample[31:0], entry_index, entry_red,
                                         // entry_green, entry_blue
    input  wire logic        i_s_tuser,  // action

    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic      [23:0] o_m_tdata,  // red, green, blue
    output logic             o_m_tlast,  // last_copy

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    t_cfg     r_cfg;
    t_reg_idx reg_sel;
    logic     cfg_wr;

    logic     q_full;
    logic     q_push;
    t_item    q_in;
    logic     q_pop;
    logic     q_valid;
    t_item    q_head;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_cut      <= 32'sd0;
            r_cfg.high_cut     <= 32'sd255;
            r_cfg.index_gain   <= 32'd65536;
            r_cfg.log_span     <= 16'd255;
            r_cfg.display_mode <= 3'd0;
            r_cfg.color_count  <= 9'd256;
            r_cfg.repeat_count <= 5'd1;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_LOW_CUT:      r_cfg.low_cut      <= signed'(pwdata);
                REG_HIGH_CUT:     r_cfg.high_cut     <= signed'(pwdata);
                REG_INDEX_GAIN:   r_cfg.index_gain   <= pwdata;
                REG_LOG_SPAN:     r_cfg.log_span     <= pwdata[15:0];
                REG_DISPLAY_MODE: r_cfg.display_mode <= pwdata[2:0];
                REG_COLOR_COUNT:  r_cfg.color_count  <= pwdata[8:0];
                REG_REPEAT_COUNT: r_cfg.repeat_count <= pwdata[4:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_LOW_CUT:      prdata = r_cfg.low_cut;
            REG_HIGH_CUT:     prdata = r_cfg.high_cut;
            REG_INDEX_GAIN:   prdata = r_cfg.index_gain;
            REG_LOG_SPAN:     prdata = {16'b0, r_cfg.log_span};
            REG_DISPLAY_MODE: prdata = {29'b0, r_cfg.display_mode};
            REG_COLOR_COUNT:  prdata = {23'b0, r_cfg.color_count};
            REG_REPEAT_COUNT: prdata = {27'b0, r_cfg.repeat_count};
            default:          prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front: accept, classify, clip and offset each sample
    // ---------------------------------------------------------------
    stcm_front u_front (
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_kind  (i_s_tuser),
        .i_cfg   (r_cfg),
        .i_full  (q_full),
        .o_ready (o_s_tready),
        .o_push  (q_push),
        .o_item  (q_in)
    );

    // Short queue lets the input keep flowing while the back end is held
    stcm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_head)
    );

    // ---------------------------------------------------------------
    // Back: gain, log curve, wrap, reverse, colormap, copies
    // ---------------------------------------------------------------
    stcm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_pixel   (o_m_tdata),
        .o_last    (o_m_tlast)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // Copies of one pixel go out without a gap in valid
    a_copies_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && !o_m_tlast |=> o_m_tvalid)
        else $error("output dropped valid between copies of a pixel");

    // With a single copy per pixel every transfer closes the pixel
    a_single_copy_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (r_cfg.repeat_count <= 5'd1) |-> o_m_tlast)
        else $error("single-copy pixel missing its last mark");

    // Reset empties the output
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

`default_nettype wire
